// File: hw/rtl/nhs_pkg.sv
// ----------------------------------------------------------------------------
// nhs_pkg
// Shared widths, types, stage positions and saturation helpers of the
// neo-Hookean stress pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nhs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int OUT_W     = 48;
    localparam int DIV_W     = 48;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int ORDER     = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MODULUS = 8'd1;

    localparam int STG_DIV0 = 7;
    localparam int STG_INV  = STG_DIV0 + DIV_W;
    localparam int STG_S    = STG_INV + 2;
    localparam int NSTAGE   = STG_S + 3;

    localparam int NXT1 [ORDER] = '{1, 2, 0};
    localparam int NXT2 [ORDER] = '{2, 0, 1};

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic signed [OUT_W-1:0]  q32_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  wide_t;

    typedef struct packed {
        logic ov;
        q16_t v;
    } sat32_t;

    typedef struct packed {
        logic ov;
        q32_t v;
    } sat48_t;

    typedef struct packed {
        logic sing;
        logic ov_e;
        logic ov_l;
    } flags_t;

    typedef struct packed {
        q16_t                     k;
        flags_t                   fl;
        logic [ORDER*ORDER-1:0]   qneg;
    } side_t;

    function automatic wide_t floor16(input wide_t x);
        return x >>> FRAC_W;
    endfunction

    function automatic sat32_t sat32(input wide_t x);
        sat32_t r;
        r.ov = !((x[SUM_W-1:DATA_W-1] == '0) || (x[SUM_W-1:DATA_W-1] == '1));
        if (r.ov)
        begin
            r.v = x[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r.v = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic sat48_t sat48(input wide_t x);
        sat48_t r;
        r.ov = !((x[SUM_W-1:OUT_W-1] == '0) || (x[SUM_W-1:OUT_W-1] == '1));
        if (r.ov)
        begin
            r.v = x[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            r.v = x[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/nhs_div.sv
// ----------------------------------------------------------------------------
// nhs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nhs_div
    import nhs_pkg::*;
#(
    parameter int NUM_W = DIV_W,
    parameter int DEN_W = DATA_W
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                nq_reg[s]  <= {nq_in[NUM_W-2:0], take};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/neo_hookean_stress.sv
// ----------------------------------------------------------------------------
// neo_hookean_stress
// Compressible neo-Hookean first Piola-Kirchhoff stress, one quadrature point
// per transfer, fully pipelined.
// ----------------------------------------------------------------------------
// The slave stream carries the nine entries of the deformation gradient F in
// signed Q16.16. The master stream returns the nine entries of P in signed
// Q32.16, with the singular and overflow flags in tuser.
// The configuration channel writes the Lame constants; it is always ready and
// should only be used while no point is in flight.
// The pipeline is 60 stages deep. One point can enter in every cycle while
// the receiver keeps tready high. The depth is set by the 48-stage restoring
// divider that forms the inverse of C, one quotient bit per stage.
// Reset clears all valid bits and both constants.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module neo_hookean_stress
    import nhs_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // deform_r1c1, r1c2, r1c3, r2c1, ..., r3c3 from the lowest bit up.
    input  wire logic [ORDER*ORDER*DATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // stress_r1c1, r1c2, r1c3, r2c1, ..., r3c3 from the lowest bit up.
    output logic [ORDER*ORDER*OUT_W-1:0]    m_tdata,
    // singular_flag, overflow_flag from the lowest bit up.
    output logic [1:0]                      m_tuser,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [DATA_W-1:0]          cfg_data
);

    logic [DATA_W-1:0] lam_reg;
    logic [DATA_W-1:0] mu_reg;
    logic              adv;
    logic              vld_reg [NSTAGE];

    q16_t   fin       [ORDER][ORDER];
    q16_t   f_pipe    [STG_S+1][ORDER][ORDER];

    prod_t  cprod_reg [ORDER][ORDER][ORDER];
    q16_t   c2_reg    [ORDER][ORDER];
    logic   ov2_reg;
    prod_t  aprod_reg [ORDER][ORDER][2];
    q16_t   c3_reg    [ORDER];
    logic   ov3_reg;
    q16_t   a4_reg    [ORDER][ORDER];
    q16_t   c4_reg    [ORDER];
    logic   ov4_reg;
    prod_t  dprod_reg [ORDER];
    q16_t   a5_reg    [ORDER][ORDER];
    logic   ov5_reg;
    q16_t   det6_reg;
    q16_t   a6_reg    [ORDER][ORDER];
    logic   ov6_reg;
    logic [DIV_W-1:0]  num7_reg [ORDER][ORDER];
    logic [ORDER*ORDER-1:0] qneg7_reg;
    logic [DATA_W-1:0] den7_reg;
    logic              sing7_reg;
    logic [PROD_W-1:0] lp7_reg;
    logic              dneg7_reg;
    logic              ov7_reg;

    side_t  side_pipe [DIV_W];
    logic [DIV_W-1:0]  quo [ORDER][ORDER];

    q16_t   inv_reg   [ORDER][ORDER];
    q16_t   k55_reg;
    flags_t fl55_reg;
    prod_t  kprod_reg [ORDER][ORDER];
    flags_t fl56_reg;
    q16_t   s_reg     [ORDER][ORDER];
    flags_t fl57_reg;
    prod_t  pprod_reg [ORDER][ORDER][ORDER];
    flags_t fl58_reg;
    q32_t   out_reg   [ORDER][ORDER];
    logic   sing_out_reg;
    logic   ov_out_reg;

    q16_t   c2_next   [ORDER][ORDER];
    logic   ov2_next;
    q16_t   a4_next   [ORDER][ORDER];
    logic   ov4_next;
    sat32_t det6_next;
    side_t  side_next;
    q16_t   inv_next  [ORDER][ORDER];
    logic   ov55_next;
    q16_t   s_next    [ORDER][ORDER];
    logic   ov57_next;
    q32_t   out_next  [ORDER][ORDER];
    logic   ovp_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lam_reg <= '0;
            mu_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LAME_LAMBDA:   lam_reg <= cfg_data;
                REG_SHEAR_MODULUS: mu_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign adv      = !vld_reg[NSTAGE-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int s = 1; s < NSTAGE; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ORDER; i++)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                fin[i][j] = s_tdata[(i*ORDER+j)*DATA_W +: DATA_W];
            end
        end
    end

    always_comb
    begin
        sat32_t r;
        ov2_next = 1'b0;
        ov4_next = 1'b0;
        for (int i = 0; i < ORDER; i++)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                r = sat32(floor16(wide_t'(cprod_reg[i][j][0]) + wide_t'(cprod_reg[i][j][1])
                                  + wide_t'(cprod_reg[i][j][2])));
                c2_next[i][j] = r.v;
                ov2_next      = ov2_next | r.ov;
                r = sat32(floor16(wide_t'(aprod_reg[i][j][0]) - wide_t'(aprod_reg[i][j][1])));
                a4_next[i][j] = r.v;
                ov4_next      = ov4_next | r.ov;
            end
        end
    end

    assign det6_next = sat32(floor16(wide_t'(dprod_reg[0]) + wide_t'(dprod_reg[1])
                                     + wide_t'(dprod_reg[2])));

    always_comb
    begin
        logic [DIV_W-1:0] kmag;
        wide_t            kw;
        sat32_t           r;
        if (dneg7_reg)
        begin
            kmag = DIV_W'(({1'b0, lp7_reg} + 65'd131071) >> (FRAC_W + 1));
            kw   = -$signed({{(SUM_W-DIV_W){1'b0}}, kmag});
        end
        else
        begin
            kmag = DIV_W'(lp7_reg >> (FRAC_W + 1));
            kw   = $signed({{(SUM_W-DIV_W){1'b0}}, kmag});
        end
        r = sat32(kw - $signed({{(SUM_W-DATA_W){1'b0}}, mu_reg}));
        side_next.k       = r.v;
        side_next.fl.sing = sing7_reg;
        side_next.fl.ov_e = ov7_reg;
        side_next.fl.ov_l = r.ov;
        side_next.qneg    = qneg7_reg;
    end

    always_comb
    begin
        side_t  sd;
        wide_t  qw;
        sat32_t r;
        sd        = side_pipe[DIV_W-1];
        ov55_next = sd.fl.ov_l;
        for (int i = 0; i < ORDER; i++)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                qw = $signed({{(SUM_W-DIV_W){1'b0}}, quo[i][j]});
                if (sd.qneg[i*ORDER+j])
                begin
                    qw = -qw;
                end
                r = sat32(qw);
                inv_next[i][j] = r.v;
                ov55_next      = ov55_next | r.ov;
            end
        end
    end

    always_comb
    begin
        wide_t  sw;
        sat32_t r;
        ov57_next = fl56_reg.ov_l;
        for (int i = 0; i < ORDER; i++)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                sw = floor16(wide_t'(kprod_reg[i][j]));
                if (i == j)
                begin
                    sw = sw + $signed({{(SUM_W-DATA_W){1'b0}}, mu_reg});
                end
                r = sat32(sw);
                s_next[i][j] = r.v;
                ov57_next    = ov57_next | r.ov;
            end
        end
    end

    always_comb
    begin
        sat48_t r;
        ovp_next = 1'b0;
        for (int i = 0; i < ORDER; i++)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                r = sat48(floor16(wide_t'(pprod_reg[i][j][0]) + wide_t'(pprod_reg[i][j][1])
                                  + wide_t'(pprod_reg[i][j][2])));
                out_next[i][j] = r.v;
                ovp_next       = ovp_next | r.ov;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_pipe[0] <= fin;
            for (int s = 1; s <= STG_S; s++)
            begin
                f_pipe[s] <= f_pipe[s-1];
            end

            for (int i = 0; i < ORDER; i++)
            begin
                for (int j = 0; j < ORDER; j++)
                begin
                    for (int m = 0; m < ORDER; m++)
                    begin
                        cprod_reg[i][j][m] <= prod_t'(fin[m][i]) * prod_t'(fin[m][j]);
                    end
                end
            end

            c2_reg  <= c2_next;
            ov2_reg <= ov2_next;

            for (int i = 0; i < ORDER; i++)
            begin
                for (int j = 0; j < ORDER; j++)
                begin
                    aprod_reg[i][j][0] <= prod_t'(c2_reg[NXT1[j]][NXT1[i]])
                                          * prod_t'(c2_reg[NXT2[j]][NXT2[i]]);
                    aprod_reg[i][j][1] <= prod_t'(c2_reg[NXT1[j]][NXT2[i]])
                                          * prod_t'(c2_reg[NXT2[j]][NXT1[i]]);
                end
            end
            c3_reg  <= c2_reg[0];
            ov3_reg <= ov2_reg;

            a4_reg  <= a4_next;
            c4_reg  <= c3_reg;
            ov4_reg <= ov3_reg | ov4_next;

            for (int j = 0; j < ORDER; j++)
            begin
                dprod_reg[j] <= prod_t'(c4_reg[j]) * prod_t'(a4_reg[j][0]);
            end
            a5_reg  <= a4_reg;
            ov5_reg <= ov4_reg;

            det6_reg <= det6_next.v;
            a6_reg   <= a5_reg;
            ov6_reg  <= ov5_reg | det6_next.ov;

            for (int i = 0; i < ORDER; i++)
            begin
                for (int j = 0; j < ORDER; j++)
                begin
                    num7_reg[i][j] <= {(a6_reg[i][j][DATA_W-1] ? DATA_W'(-a6_reg[i][j])
                                                            : DATA_W'(a6_reg[i][j])),
                                       {FRAC_W{1'b0}}};
                    qneg7_reg[i*ORDER+j] <= a6_reg[i][j][DATA_W-1] ^ det6_reg[DATA_W-1];
                end
            end
            den7_reg  <= det6_reg[DATA_W-1] ? DATA_W'(-det6_reg) : DATA_W'(det6_reg);
            sing7_reg <= (det6_reg == '0);
            begin
                logic signed [DATA_W:0] dd;
                logic [DATA_W-1:0]      dmag;
                dd   = {det6_reg[DATA_W-1], det6_reg} - (33'sd1 <<< FRAC_W);
                dmag = dd[DATA_W] ? DATA_W'(-dd) : dd[DATA_W-1:0];
                lp7_reg   <= PROD_W'(lam_reg) * PROD_W'(dmag);
                dneg7_reg <= dd[DATA_W];
            end
            ov7_reg <= ov6_reg;

            side_pipe[0] <= side_next;
            for (int s = 1; s < DIV_W; s++)
            begin
                side_pipe[s] <= side_pipe[s-1];
            end

            inv_reg       <= inv_next;
            k55_reg       <= side_pipe[DIV_W-1].k;
            fl55_reg.sing <= side_pipe[DIV_W-1].fl.sing;
            fl55_reg.ov_e <= side_pipe[DIV_W-1].fl.ov_e;
            fl55_reg.ov_l <= ov55_next;

            for (int i = 0; i < ORDER; i++)
            begin
                for (int j = 0; j < ORDER; j++)
                begin
                    kprod_reg[i][j] <= prod_t'(k55_reg) * prod_t'(inv_reg[i][j]);
                end
            end
            fl56_reg <= fl55_reg;

            s_reg         <= s_next;
            fl57_reg.sing <= fl56_reg.sing;
            fl57_reg.ov_e <= fl56_reg.ov_e;
            fl57_reg.ov_l <= ov57_next;

            for (int i = 0; i < ORDER; i++)
            begin
                for (int j = 0; j < ORDER; j++)
                begin
                    for (int m = 0; m < ORDER; m++)
                    begin
                        pprod_reg[i][j][m] <= prod_t'(f_pipe[STG_S][i][m])
                                              * prod_t'(s_reg[m][j]);
                    end
                end
            end
            fl58_reg <= fl57_reg;

            for (int i = 0; i < ORDER; i++)
            begin
                for (int j = 0; j < ORDER; j++)
                begin
                    out_reg[i][j] <= fl58_reg.sing ? '0 : out_next[i][j];
                end
            end
            sing_out_reg <= fl58_reg.sing;
            ov_out_reg   <= fl58_reg.sing ? fl58_reg.ov_e
                                          : (fl58_reg.ov_e | fl58_reg.ov_l | ovp_next);
        end
    end

    for (genvar gi = 0; gi < ORDER; gi++)
    begin : g_row
        for (genvar gj = 0; gj < ORDER; gj++)
        begin : g_col
            nhs_div #(
                .NUM_W (DIV_W),
                .DEN_W (DATA_W)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .num (num7_reg[gi][gj]),
                .den (den7_reg),
                .quo (quo[gi][gj])
            );
        end
    end

    always_comb
    begin
        for (int i = 0; i < ORDER; i++)
        begin
            for (int j = 0; j < ORDER; j++)
            begin
                m_tdata[(i*ORDER+j)*OUT_W +: OUT_W] = out_reg[i][j];
            end
        end
    end

    assign m_tuser = {ov_out_reg, sing_out_reg};

endmodule

`default_nettype wire
